>>> hw/rtl/tcw_pkg.sv
// Shared constants, codes and types for the text console character writer.
// Depends on nothing; every other file of the block imports it.
package tcw_pkg;

   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int TAB_WIDTH  = 8;
   localparam int CELL_COUNT = COLUMNS * ROWS;

   localparam int COL_W       = $clog2(COLUMNS);
   localparam int ROW_W       = $clog2(ROWS);
   localparam int MEM_AW      = $clog2(CELL_COUNT);
   localparam int CMD_W       = 2;
   localparam int CHAR_W      = 8;
   localparam int COLOR_W     = 4;
   localparam int CELL_ADDR_W = 11;
   localparam int LOC_W       = 11;
   localparam int CELL_W      = 16;

   localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;

   localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

   localparam logic [CHAR_W-1:0] CHAR_BS       = 8'h08;
   localparam logic [CHAR_W-1:0] CHAR_TAB      = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_LF       = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_CR       = 8'h0D;
   localparam logic [CHAR_W-1:0] CHAR_PRINT_LO = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_PRINT_HI = 8'h7F;

   localparam int KIND_W = 3;
   localparam logic [KIND_W-1:0] K_NONE  = 3'd0;
   localparam logic [KIND_W-1:0] K_PRINT = 3'd1;
   localparam logic [KIND_W-1:0] K_BS    = 3'd2;
   localparam logic [KIND_W-1:0] K_TAB   = 3'd3;
   localparam logic [KIND_W-1:0] K_CR    = 3'd4;
   localparam logic [KIND_W-1:0] K_LF    = 3'd5;
   localparam logic [KIND_W-1:0] K_CLEAR = 3'd6;
   localparam logic [KIND_W-1:0] K_READ  = 3'd7;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic [KIND_W-1:0]      kind;
      logic [CELL_W-1:0]      cell_value;
      logic [CELL_ADDR_W-1:0] addr;
   } op_type;

   typedef logic [COLUMNS-1:0][COL_W:0] tab_table_type;

   function automatic tab_table_type build_tab_table();
      tab_table_type t;
      int nx;
      for (int i = 0; i < COLUMNS; i++) begin
         nx = i + TAB_WIDTH - (i % TAB_WIDTH);
         if (nx > COLUMNS) begin
            nx = COLUMNS;
         end
         t[i] = (COL_W + 1)'(nx);
      end
      return t;
   endfunction

   localparam tab_table_type TAB_NEXT = build_tab_table();

endpackage

>>> hw/rtl/tcw_front.sv
// Front end: takes request words and classifies them into queue operations.
// Depends on tcw_pkg.
module tcw_front (
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [tcw_pkg::CMD_W-1:0]       req_command,
   input  logic [tcw_pkg::CHAR_W-1:0]      req_char_code,
   input  logic [tcw_pkg::COLOR_W-1:0]     req_back_color,
   input  logic [tcw_pkg::COLOR_W-1:0]     req_front_color,
   input  logic [tcw_pkg::CELL_ADDR_W-1:0] req_cell_address,
   input  logic                            init_busy,
   input  logic                            q_full,
   output logic                            q_push,
   output tcw_pkg::op_type                 q_push_op
);
   import tcw_pkg::*;

   logic printable;

   assign req_ready = !q_full && !init_busy;
   assign q_push    = req_valid && req_ready;
   assign printable = (req_char_code >= CHAR_PRINT_LO) && (req_char_code <= CHAR_PRINT_HI);

   always_comb begin
      q_push_op.cell_value = {req_back_color, req_front_color, req_char_code};
      q_push_op.addr       = req_cell_address;
      q_push_op.kind       = K_NONE;
      case (req_command)
         CMD_PUT: begin
            if (req_char_code == CHAR_BS) begin
               q_push_op.kind = K_BS;
            end else if (req_char_code == CHAR_TAB) begin
               q_push_op.kind = K_TAB;
            end else if (req_char_code == CHAR_CR) begin
               q_push_op.kind = K_CR;
            end else if (req_char_code == CHAR_LF) begin
               q_push_op.kind = K_LF;
            end else if (printable) begin
               q_push_op.kind = K_PRINT;
            end
         end
         CMD_CLEAR: begin
            q_push_op.kind = K_CLEAR;
         end
         CMD_READ: begin
            if (32'(req_cell_address) < 32'(CELL_COUNT)) begin
               q_push_op.kind = K_READ;
            end
         end
         default: begin
            q_push_op.kind = K_NONE;
         end
      endcase
   end

endmodule

>>> hw/rtl/tcw_queue.sv
// Short operation queue between the front end and the screen engine.
// Depends on tcw_pkg for the operation type and the depth.
module tcw_queue (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  tcw_pkg::op_type push_op,
   output logic            full,
   input  logic            pop,
   output tcw_pkg::op_type head_op,
   output logic            empty
);
   import tcw_pkg::*;

   op_type              entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     count_ff, count_in;
   logic                do_push, do_pop;

   assign full    = (count_ff == (QPTR_W + 1)'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head_op = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

>>> hw/rtl/tcw_back.sv
// Screen engine: owns the cell memory, the cursor and the scroll offset, and
// carries out queued operations. Depends on tcw_pkg.
module tcw_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      q_empty,
   input  tcw_pkg::op_type           q_head_op,
   output logic                      q_pop,
   output logic                      init_busy,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [tcw_pkg::LOC_W-1:0] rsp_cursor_location,
   output logic [tcw_pkg::CELL_W-1:0] rsp_cell_data
);
   import tcw_pkg::*;

   localparam int ST_W = 3;
   localparam logic [ST_W-1:0] ST_SWEEP = 3'd0;
   localparam logic [ST_W-1:0] ST_IDLE  = 3'd1;
   localparam logic [ST_W-1:0] ST_EXEC  = 3'd2;
   localparam logic [ST_W-1:0] ST_WRITE = 3'd3;
   localparam logic [ST_W-1:0] ST_ADV   = 3'd4;
   localparam logic [ST_W-1:0] ST_BLANK = 3'd5;
   localparam logic [ST_W-1:0] ST_READ  = 3'd6;
   localparam logic [ST_W-1:0] ST_REPLY = 3'd7;

   logic [CELL_W-1:0] mem [CELL_COUNT];

   logic [ST_W-1:0]   state_ff, state_in;
   op_type            op_ff, op_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [MEM_AW-1:0] base_ff, base_in;
   logic [MEM_AW-1:0] phys_ff, phys_in;
   logic [COL_W:0]    col_nx_ff, col_nx_in;
   logic              row_inc_ff, row_inc_in;
   logic [MEM_AW-1:0] ptr_ff, ptr_in;
   logic [COL_W-1:0]  blank_cnt_ff, blank_cnt_in;
   logic              reply_ff, reply_in;
   logic              init_ff, init_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [LOC_W-1:0]  loc_ff, loc_in;
   logic [CELL_W-1:0] data_ff, data_in;
   logic [CELL_W-1:0] rd_data_ff;

   logic              we;
   logic [MEM_AW-1:0] waddr;
   logic [CELL_W-1:0] wdata;
   logic              out_free;
   logic              wrap;

   function automatic logic [MEM_AW-1:0] wrap_add(logic [MEM_AW-1:0] a,
                                                  logic [MEM_AW-1:0] b);
      logic [MEM_AW:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= (MEM_AW + 1)'(CELL_COUNT)) begin
         s = s - (MEM_AW + 1)'(CELL_COUNT);
      end
      return s[MEM_AW-1:0];
   endfunction

   function automatic logic [MEM_AW-1:0] cell_index(logic [ROW_W-1:0] r,
                                                    logic [COL_W-1:0] c);
      return MEM_AW'(MEM_AW'(r) * MEM_AW'(COLUMNS)) + MEM_AW'(c);
   endfunction

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign init_busy = init_ff;
   assign q_pop     = (state_ff == ST_IDLE) && !q_empty;
   assign wrap      = (col_nx_ff >= (COL_W + 1)'(COLUMNS));

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_cursor_location = loc_ff;
   assign rsp_cell_data       = data_ff;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      base_in      = base_ff;
      phys_in      = phys_ff;
      col_nx_in    = col_nx_ff;
      row_inc_in   = row_inc_ff;
      ptr_in       = ptr_ff;
      blank_cnt_in = blank_cnt_ff;
      reply_in     = reply_ff;
      init_in      = init_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      loc_in       = loc_ff;
      data_in      = data_ff;
      we           = 1'b0;
      waddr        = ptr_ff;
      wdata        = BLANK_CELL;
      case (state_ff)
         ST_SWEEP: begin
            we     = 1'b1;
            ptr_in = ptr_ff + 1'b1;
            if (ptr_ff == MEM_AW'(CELL_COUNT - 1)) begin
               init_in  = 1'b0;
               state_in = reply_ff ? ST_REPLY : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!q_empty) begin
               op_in    = q_head_op;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            row_inc_in = (op_ff.kind == K_LF);
            col_nx_in  = {1'b0, col_ff};
            phys_in    = wrap_add(cell_index(row_ff, col_ff), base_ff);
            state_in   = ST_ADV;
            case (op_ff.kind)
               K_PRINT: begin
                  col_nx_in = {1'b0, col_ff} + 1'b1;
                  state_in  = ST_WRITE;
               end
               K_BS: begin
                  col_nx_in = (col_ff == '0) ? '0 : {1'b0, col_ff} - 1'b1;
               end
               K_TAB: begin
                  col_nx_in = TAB_NEXT[col_ff];
               end
               K_CR, K_LF: begin
                  col_nx_in = '0;
               end
               K_CLEAR: begin
                  col_in   = '0;
                  row_in   = '0;
                  base_in  = '0;
                  ptr_in   = '0;
                  reply_in = 1'b1;
                  state_in = ST_SWEEP;
               end
               K_READ: begin
                  phys_in  = wrap_add(MEM_AW'(op_ff.addr), base_ff);
                  state_in = ST_READ;
               end
               default: begin
                  col_nx_in = {1'b0, col_ff};
               end
            endcase
         end
         ST_WRITE: begin
            we       = 1'b1;
            waddr    = phys_ff;
            wdata    = op_ff.cell_value;
            state_in = ST_ADV;
         end
         ST_ADV: begin
            col_in   = wrap ? '0 : col_nx_ff[COL_W-1:0];
            state_in = ST_REPLY;
            if (row_inc_ff || wrap) begin
               if (row_ff == ROW_W'(ROWS - 1)) begin
                  ptr_in       = base_ff;
                  base_in      = wrap_add(base_ff, MEM_AW'(COLUMNS));
                  blank_cnt_in = '0;
                  state_in     = ST_BLANK;
               end else begin
                  row_in = row_ff + 1'b1;
               end
            end
         end
         ST_BLANK: begin
            we           = 1'b1;
            ptr_in       = ptr_ff + 1'b1;
            blank_cnt_in = blank_cnt_ff + 1'b1;
            if (blank_cnt_ff == COL_W'(COLUMNS - 1)) begin
               state_in = ST_REPLY;
            end
         end
         ST_READ: begin
            state_in = ST_REPLY;
         end
         ST_REPLY: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               loc_in       = LOC_W'(cell_index(row_ff, col_ff));
               data_in      = (op_ff.kind == K_READ) ? rd_data_ff : '0;
               reply_in     = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         col_ff       <= '0;
         row_ff       <= '0;
         base_ff      <= '0;
         ptr_ff       <= '0;
         reply_ff     <= 1'b0;
         init_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         base_ff      <= base_in;
         ptr_ff       <= ptr_in;
         reply_ff     <= reply_in;
         init_ff      <= init_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      phys_ff      <= phys_in;
      col_nx_ff    <= col_nx_in;
      row_inc_ff   <= row_inc_in;
      blank_cnt_ff <= blank_cnt_in;
      loc_ff       <= loc_in;
      data_ff      <= data_in;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rd_data_ff <= mem[phys_ff];
   end

endmodule

>>> hw/rtl/text_console_char_writer_core.sv
// Top level of the text console character writer: front end, queue and engine.
// Depends on tcw_pkg, tcw_front, tcw_queue and tcw_back.
//
//   Port group  Direction  Word carried
//   req_        in         command, character, colours and cell address
//   rsp_        out        cursor location and cell contents
//
// In the engine a put of a printable character passes the execute, write,
// advance and reply states; other puts and unused commands skip the write, and
// reads of a cell on the screen go through execute, read and reply. A put that
// scrolls also blanks the new bottom row cell by cell, and a clear blanks all
// cells; the single write port of the cell memory sets this pace. After reset
// the memory is blanked cell by cell, 2000 cells at 80x25, with req_ready low.
// Up to four words wait in the queue while the engine or rsp_ is stalled.
module text_console_char_writer_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [tcw_pkg::CMD_W-1:0]       req_command,
   input  logic [tcw_pkg::CHAR_W-1:0]      req_char_code,
   input  logic [tcw_pkg::COLOR_W-1:0]     req_back_color,
   input  logic [tcw_pkg::COLOR_W-1:0]     req_front_color,
   input  logic [tcw_pkg::CELL_ADDR_W-1:0] req_cell_address,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [tcw_pkg::LOC_W-1:0]       rsp_cursor_location,
   output logic [tcw_pkg::CELL_W-1:0]      rsp_cell_data
);
   import tcw_pkg::*;

   logic   init_busy;
   logic   q_full, q_empty, q_push, q_pop;
   op_type q_push_op, q_head_op;

   tcw_front u_front (
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_char_code    (req_char_code),
      .req_back_color   (req_back_color),
      .req_front_color  (req_front_color),
      .req_cell_address (req_cell_address),
      .init_busy        (init_busy),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_push_op        (q_push_op)
   );

   tcw_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .push_op (q_push_op),
      .full    (q_full),
      .pop     (q_pop),
      .head_op (q_head_op),
      .empty   (q_empty)
   );

   tcw_back u_back (
      .clock               (clock),
      .reset               (reset),
      .q_empty             (q_empty),
      .q_head_op           (q_head_op),
      .q_pop               (q_pop),
      .init_busy           (init_busy),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_cursor_location (rsp_cursor_location),
      .rsp_cell_data       (rsp_cell_data)
   );

endmodule

>>> hw/rtl/tcw_checker.sv
// Port-level checks for the text console character writer, bound to its top.
// Depends on tcw_pkg and text_console_char_writer_core.
module tcw_port_checks (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic [tcw_pkg::CMD_W-1:0]       req_command,
   input logic [tcw_pkg::CHAR_W-1:0]      req_char_code,
   input logic [tcw_pkg::COLOR_W-1:0]     req_back_color,
   input logic [tcw_pkg::COLOR_W-1:0]     req_front_color,
   input logic [tcw_pkg::CELL_ADDR_W-1:0] req_cell_address,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [tcw_pkg::LOC_W-1:0]       rsp_cursor_location,
   input logic [tcw_pkg::CELL_W-1:0]      rsp_cell_data
);
   import tcw_pkg::*;

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 3);

   logic [CNT_W-1:0] pending_ff, pending_in;
   logic             req_acc, rsp_acc;

   assign req_acc = req_valid && req_ready;
   assign rsp_acc = rsp_valid && rsp_ready;

   always_comb begin
      pending_in = pending_ff;
      if (req_acc && !rsp_acc) begin
         pending_in = pending_ff + 1'b1;
      end else if (rsp_acc && !req_acc) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_ready_low_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("req_ready high while the screen is being blanked");

   a_rsp_has_request: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (pending_ff != '0))
      else $error("response word without an outstanding request");

   a_pending_bounded: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= CNT_W'(QUEUE_DEPTH + 2))
      else $error("more requests outstanding than the block can hold");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cursor_location)
                                  && $stable(rsp_cell_data))
      else $error("stalled response word changed or was withdrawn");

   a_location_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_cursor_location) < 32'(CELL_COUNT)))
      else $error("cursor location beyond the screen");

endmodule

bind text_console_char_writer_core tcw_port_checks u_checker (.*);
